// File: rtl/lrsp_pkg.sv
package lrsp_pkg;

  typedef enum logic [2:0] {
    MODE_BOOT    = 3'd0,
    MODE_CONNECT = 3'd1,
    MODE_IDLE    = 3'd2,
    MODE_TX      = 3'd3,
    MODE_RX      = 3'd4,
    MODE_MUTED   = 3'd5,
    MODE_ERROR   = 3'd6
  } mode_t;

  // configuration register map
  localparam int unsigned CFG_AW       = 3;
  localparam logic        REG_RING_LEN = 1'b0;
  localparam logic [6:0]  RING_LEN_RST = 7'd12;

  localparam logic [6:0]  VOL_FULL      = 7'd100;
  localparam logic [3:0]  BLINK_PERIOD  = 4'd10;
  localparam logic [3:0]  BLINK_ON      = 4'd5;

  localparam logic [23:0] RGB_BOOT_BG  = 24'h000010;
  localparam logic [23:0] RGB_BLUE     = 24'h0000FF;
  localparam logic [23:0] RGB_VOL_ON   = 24'h0040FF;
  localparam logic [23:0] RGB_VOL_OFF  = 24'h050505;
  localparam logic [23:0] RGB_VU_OFF   = 24'h040404;
  localparam logic [23:0] RGB_GREEN    = 24'h00FF00;
  localparam logic [23:0] RGB_RED      = 24'hFF0000;
  localparam logic [23:0] RGB_ERR_ON   = 24'hFF4500;
  localparam logic [23:0] RGB_ERR_OFF  = 24'h202000;
  localparam logic [23:0] RGB_BLACK    = 24'h000000;

  // raised-cosine breathing curve, 20 + 40*(1 - cos(2*pi*k/40)) with pi = 3.14159
  localparam int unsigned BREATHE_LEN   = 40;
  localparam logic [7:0]  BREATHE_FLOOR = 8'd20;
  localparam logic [7:0] BREATHE_TABLE [BREATHE_LEN] = '{
    8'd20, 8'd20, 8'd21, 8'd24, 8'd27, 8'd31, 8'd36, 8'd41, 8'd47, 8'd53,
    8'd59, 8'd66, 8'd72, 8'd78, 8'd83, 8'd88, 8'd92, 8'd95, 8'd98, 8'd99,
    8'd100, 8'd99, 8'd98, 8'd95, 8'd92, 8'd88, 8'd83, 8'd78, 8'd72, 8'd66,
    8'd60, 8'd53, 8'd47, 8'd41, 8'd36, 8'd31, 8'd27, 8'd24, 8'd21, 8'd20
  };

  function automatic logic [7:0] breathe_level(input logic [7:0] k);
    logic [7:0] b;
    if (k < 8'(BREATHE_LEN)) begin
      b = BREATHE_TABLE[k[5:0]];
    end else begin
      b = BREATHE_FLOOR;
    end
    return b;
  endfunction

  typedef struct packed {
    logic load;  // capture the frame tick transaction
    logic emit;  // push one pixel into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;  // output register can take a pixel this cycle
    logic at_last;    // current pixel is the final LED
  } ctrl_status_t;

endpackage

// File: rtl/lrsp_in_if.sv
interface lrsp_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [6:0] volume_percent;
  logic [8:0] vu_level;

  modport source (output valid, output mode, output volume_percent, output vu_level,
                  input ready);
  modport sink (input valid, input mode, input volume_percent, input vu_level,
                output ready);
endinterface

// File: rtl/lrsp_out_if.sv
interface lrsp_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;

  modport source (output valid, output pixel_index, output red, output green, output blue,
                  output last_pixel, input ready);
  modport sink (input valid, input pixel_index, input red, input green, input blue,
                input last_pixel, output ready);
endinterface

// File: rtl/lrsp_ctrl.sv
module lrsp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lrsp_pkg::ctrl_status_t st,
  output lrsp_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (st.slot_free && st.at_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign cmd.load = in_valid && in_ready;
  assign cmd.emit = (state_r == S_RUN) && st.slot_free;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.slot_free)
    else $error("pixel pushed into an occupied output register");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && st.at_last |=> state_r == S_IDLE)
    else $error("frame did not end after its final pixel");

  a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) && !cmd.emit |=> state_r == S_RUN)
    else $error("frame dropped while output stalled");

endmodule

// File: rtl/lrsp_datapath.sv
module lrsp_datapath #(
  parameter int unsigned MAX_LEDS      = 64,
  parameter int unsigned BREATHE_STEPS = 40,
  localparam int unsigned NW   = $clog2(MAX_LEDS + 1),
  localparam int unsigned IDXW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1,
  localparam int unsigned BW   = (BREATHE_STEPS > 1) ? $clog2(BREATHE_STEPS) : 1,
  localparam int unsigned PW   = NW + 9
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [6:0]             ring_len,
  input  logic [2:0]             in_mode,
  input  logic [6:0]             in_volume_percent,
  input  logic [8:0]             in_vu_level,
  input  lrsp_pkg::ctrl_cmd_t    cmd,
  output lrsp_pkg::ctrl_status_t st,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [5:0]             out_pixel_index,
  output logic [7:0]             out_red,
  output logic [7:0]             out_green,
  output logic [7:0]             out_blue,
  output logic                   out_last_pixel
);

  // frame context
  lrsp_pkg::mode_t mode_r;
  logic [PW-1:0]   prod_r;
  logic [NW-1:0]   n_r;
  logic [IDXW-1:0] pix_r, pix_nxt;

  // free-running phases
  logic [BW-1:0]   breathe_r, breathe_nxt;
  logic [3:0]      blink_r, blink_nxt;
  logic            half_r;
  logic [IDXW-1:0] spin_r, spin_nxt, spin_clamp;

  logic            out_valid_r;
  logic [5:0]      out_idx_r;
  logic [23:0]     out_rgb_r;
  logic            out_last_r;

  logic [NW-1:0]   n_c;
  logic [6:0]      vol_c;
  logic [8:0]      mul_a;
  logic [PW-1:0]   prod_c;
  logic [NW-1:0]   pix_cnt;
  logic [PW-1:0]   thresh;
  logic            lit;
  logic            at_last;
  logic [7:0]      bri;
  logic [23:0]     rgb;

  // effective LED count and bar length product, taken at frame start
  always_comb begin
    if (ring_len == 7'd0) begin
      n_c = NW'(1);
    end else if (32'(ring_len) > MAX_LEDS) begin
      n_c = NW'(MAX_LEDS);
    end else begin
      n_c = NW'(ring_len);
    end
    vol_c  = (in_volume_percent > lrsp_pkg::VOL_FULL) ? lrsp_pkg::VOL_FULL
                                                      : in_volume_percent;
    mul_a  = (lrsp_pkg::mode_t'(in_mode) == lrsp_pkg::MODE_IDLE) ? {2'b00, vol_c}
                                                                 : in_vu_level;
    prod_c = PW'(mul_a) * PW'(n_c);
    spin_clamp = (NW'(spin_r) >= n_c) ? '0 : spin_r;
  end

  // LED i is lit when (i+1)*scale <= level*n, i.e. i < floor(level*n/scale);
  // for VU that bound can exceed n, since vu_level reaches 511, but i < n always keeps the bar inside the ring
  always_comb begin
    pix_cnt = NW'(pix_r) + NW'(1);
    at_last = (pix_cnt == n_r);
    if (mode_r == lrsp_pkg::MODE_IDLE) begin
      thresh = PW'(pix_cnt) * PW'(lrsp_pkg::VOL_FULL);
    end else begin
      thresh = PW'(pix_cnt) << 8;
    end
    lit = (thresh <= prod_r);
    bri = lrsp_pkg::breathe_level(8'(breathe_r));

    case (mode_r)
      lrsp_pkg::MODE_BOOT:    rgb = (pix_r == spin_r) ? lrsp_pkg::RGB_BLUE
                                                      : lrsp_pkg::RGB_BOOT_BG;
      lrsp_pkg::MODE_CONNECT: rgb = {bri, bri, bri};
      lrsp_pkg::MODE_IDLE:    rgb = lit ? lrsp_pkg::RGB_VOL_ON : lrsp_pkg::RGB_VOL_OFF;
      lrsp_pkg::MODE_TX:      rgb = lit ? lrsp_pkg::RGB_GREEN : lrsp_pkg::RGB_VU_OFF;
      lrsp_pkg::MODE_RX:      rgb = lit ? lrsp_pkg::RGB_BLUE : lrsp_pkg::RGB_VU_OFF;
      lrsp_pkg::MODE_MUTED:   rgb = lrsp_pkg::RGB_RED;
      lrsp_pkg::MODE_ERROR:   rgb = (blink_r < lrsp_pkg::BLINK_ON) ? lrsp_pkg::RGB_ERR_ON
                                                                   : lrsp_pkg::RGB_ERR_OFF;
      default:                rgb = lrsp_pkg::RGB_BLACK;
    endcase
  end

  always_comb begin
    pix_nxt     = at_last ? '0 : IDXW'(pix_cnt);
    breathe_nxt = ((BW + 1)'(breathe_r) + (BW + 1)'(1) >= (BW + 1)'(BREATHE_STEPS))
                  ? '0 : breathe_r + BW'(1);
    blink_nxt   = (blink_r + 4'd1 >= lrsp_pkg::BLINK_PERIOD) ? 4'd0 : blink_r + 4'd1;
    spin_nxt    = (NW'(spin_r) + NW'(1) >= n_r) ? '0 : spin_r + IDXW'(1);
  end

  assign st.slot_free = !out_valid_r || out_ready;
  assign st.at_last   = at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= NW'(1);
      pix_r       <= '0;
      breathe_r   <= '0;
      blink_r     <= 4'd0;
      half_r      <= 1'b0;
      spin_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        n_r    <= n_c;
        pix_r  <= '0;
        spin_r <= spin_clamp;
      end else if (cmd.emit) begin
        pix_r <= pix_nxt;
        if (at_last) begin
          breathe_r <= breathe_nxt;
          blink_r   <= blink_nxt;
          half_r    <= !half_r;
          if (half_r) begin
            spin_r <= spin_nxt;
          end
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= lrsp_pkg::mode_t'(in_mode);
      prod_r <= prod_c;
    end
    if (cmd.emit) begin
      out_idx_r  <= 6'(pix_r);
      out_rgb_r  <= rgb;
      out_last_r <= at_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_idx_r;
  assign out_red         = out_rgb_r[23:16];
  assign out_green       = out_rgb_r[15:8];
  assign out_blue        = out_rgb_r[7:0];
  assign out_last_pixel  = out_last_r;

  a_pix_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    NW'(pix_r) < n_r)
    else $error("pixel counter ran past the LED count");

  a_blink_range: assert property (@(posedge clk) disable iff (!rst_n)
    blink_r < lrsp_pkg::BLINK_PERIOD)
    else $error("blink phase out of period");

  a_spin_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> NW'(spin_r) < n_r)
    else $error("spinner not inside the ring at frame start");

endmodule

// File: rtl/led_ring_status_pattern_generator.sv
// Channel   Dir  Payload                                   Transaction
// in_ch     in   mode, volume_percent, vu_level            one frame tick
// out_ch    out  pixel_index, red, green, blue, last_pixel one LED colour
// APB       in   ring length at byte address 0             register write/read
//
// A frame tick is taken while idle, then its LEDs leave one per cycle while out_ch is
// ready; each tick runs ring length LEDs (ring length clamped to 1..MAX_LEDS) through
// the single pixel counter in the datapath. The next tick is taken while the final
// pixel still sits in the output register. Output stalls hold the pixel counter.
// Reset (rst_n, synchronous) clears all phases and sets the ring length to 12.
module led_ring_status_pattern_generator #(
  parameter int unsigned MAX_LEDS      = 64,
  parameter int unsigned BREATHE_STEPS = 40
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lrsp_in_if.sink                     in_ch,
  lrsp_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrsp_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [6:0]             ring_len_r;
  lrsp_pkg::ctrl_cmd_t    cmd;
  lrsp_pkg::ctrl_status_t st;
  logic                   cfg_wr;
  logic                   in_ready;

  // register index sits at paddr[2]; anything beyond the ring length is ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_len_r <= lrsp_pkg::RING_LEN_RST;
    end else if (cfg_wr && (paddr[2] == lrsp_pkg::REG_RING_LEN)) begin
      ring_len_r <= pwdata[6:0];
    end
  end

  assign prdata = (paddr[2] == lrsp_pkg::REG_RING_LEN) ? {25'd0, ring_len_r} : 32'd0;

  lrsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  lrsp_datapath #(
    .MAX_LEDS      (MAX_LEDS),
    .BREATHE_STEPS (BREATHE_STEPS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ring_len          (ring_len_r),
    .in_mode           (in_ch.mode),
    .in_volume_percent (in_ch.volume_percent),
    .in_vu_level       (in_ch.vu_level),
    .cmd               (cmd),
    .st                (st),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_pixel_index   (out_ch.pixel_index),
    .out_red           (out_ch.red),
    .out_green         (out_ch.green),
    .out_blue          (out_ch.blue),
    .out_last_pixel    (out_ch.last_pixel)
  );

endmodule
